FILE: rtl/core/aspf_pkg.sv
`default_nettype none
package aspf_pkg;

	localparam int BYTE_W      = 8;
	localparam int KIND_W      = 3;
	localparam int FIELD_W     = 10;
	localparam int DIGIT_W     = 4;
	localparam int QUEUE_DEPTH = 2;

	// frame kinds as reported; PENDING marks a body whose first byte is not in yet
	localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SETUP    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CRED     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CONFIRM  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CRED_ERR = 3'd4;
	localparam logic [KIND_W-1:0] KIND_STATUS   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_LIGHT    = 3'd6;
	localparam logic [KIND_W-1:0] KIND_PENDING  = 3'd7;

	// byte classes seen by the parser
	typedef enum logic [3:0] {
		CLS_OTHER,
		CLS_DIGIT,
		CLS_A,
		CLS_B,
		CLS_CRLF,
		CLS_S,
		CLS_I,
		CLS_D,
		CLS_P,
		CLS_O,
		CLS_W,
		CLS_E,
		CLS_R,
		CLS_N,
		CLS_V
	} byte_cls_t;

	typedef struct packed {
		byte_cls_t            cls;
		logic [DIGIT_W-1:0]   dval;   // low nibble of the byte, digit value for digits
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/aspf_ifs.sv
`default_nettype none
interface aspf_rx_if;
	logic                         valid;
	logic                         ready;
	logic [aspf_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface aspf_res_if;
	logic                          valid;
	logic                          ready;
	logic [aspf_pkg::KIND_W-1:0]   frame_kind;
	logic [aspf_pkg::FIELD_W-1:0]  brightness;
	logic [aspf_pkg::FIELD_W-1:0]  addr_first;
	logic [aspf_pkg::FIELD_W-1:0]  addr_second;
	logic [aspf_pkg::FIELD_W-1:0]  addr_third;
	logic [aspf_pkg::FIELD_W-1:0]  addr_fourth;
	logic [aspf_pkg::FIELD_W-1:0]  battery_level;
	logic [aspf_pkg::FIELD_W-1:0]  firmware_version;

	modport source (output valid, output frame_kind, output brightness, output addr_first,
		output addr_second, output addr_third, output addr_fourth, output battery_level,
		output firmware_version, input ready);
	modport sink   (input valid, input frame_kind, input brightness, input addr_first,
		input addr_second, input addr_third, input addr_fourth, input battery_level,
		input firmware_version, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ascii_status_frame_parser_top.sv
// channel | dir | payload                                      | beat
// --------+-----+----------------------------------------------+---------------------------
// rx      | in  | rx_byte[7:0]                                 | rx.valid && rx.ready
// res     | out | frame_kind, brightness, addr_first..fourth,  | res.valid && res.ready
//         |     | battery_level, firmware_version              |
//
// Throughput: one byte per cycle sustained while results are taken; each byte is one step of the frame
// parser in the back end, which sets that figure.
// Result path: the type byte's beat writes it into the queue; when it is popped,
// the back end parses it into the result register and res.valid rises; a held
// result delays the pop.
// Reset: arst_n clears all control state at once; no clearing pass, a byte may
// be taken in the first cycle after release.
// Stalls: a held result stops the back end; the queue then fills and rx.ready drops.
`default_nettype none
module ascii_status_frame_parser_top #(
	parameter int QUEUE_DEPTH = aspf_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	aspf_rx_if.sink     rx,
	aspf_res_if.source  res
);

	aspf_pkg::q_stat_t   q_stat;
	aspf_pkg::q_entry_t  q_in;
	aspf_pkg::q_entry_t  q_out;
	logic                q_push;
	logic                q_pop;

	// front: classify each byte
	aspf_front u_front (
		.rx    (rx),
		.qs    (q_stat),
		.push  (q_push),
		.entry (q_in)
	);

	// short queue decouples byte intake from parsing/result stalls
	aspf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.entry_in  (q_in),
		.pop       (q_pop),
		.entry_out (q_out),
		.stat      (q_stat)
	);

	// back: frame grammar, digit capture, result register
	aspf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.entry  (q_out),
		.qs     (q_stat),
		.pop    (q_pop),
		.res    (res)
	);

	// never pop an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// no byte beat into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready) |-> !q_stat.full)
		else $error("byte taken with queue full");

	// non-status results carry zero numbers
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.frame_kind != aspf_pkg::KIND_STATUS) |->
		(res.brightness == '0 && res.addr_first == '0 && res.addr_second == '0
		&& res.addr_third == '0 && res.addr_fourth == '0 && res.battery_level == '0
		&& res.firmware_version == '0))
		else $error("number fields set on non-status frame");

	// pending marker never leaks out
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.frame_kind != aspf_pkg::KIND_PENDING)
		else $error("bad frame kind");

endmodule
`default_nettype wire

FILE: rtl/core/aspf_front.sv
`default_nettype none
module aspf_front (
	aspf_rx_if.sink              rx,
	input  aspf_pkg::q_stat_t    qs,
	output logic                 push,
	output aspf_pkg::q_entry_t   entry
);

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_B  = 8'h42;
	localparam logic [7:0] CH_D  = 8'h44;
	localparam logic [7:0] CH_E  = 8'h45;
	localparam logic [7:0] CH_I  = 8'h49;
	localparam logic [7:0] CH_N  = 8'h4E;
	localparam logic [7:0] CH_O  = 8'h4F;
	localparam logic [7:0] CH_P  = 8'h50;
	localparam logic [7:0] CH_R  = 8'h52;
	localparam logic [7:0] CH_S  = 8'h53;
	localparam logic [7:0] CH_V  = 8'h56;
	localparam logic [7:0] CH_W  = 8'h57;

	assign rx.ready = !qs.full;
	assign push     = rx.valid && !qs.full;

	always_comb begin
		entry.dval = rx.rx_byte[aspf_pkg::DIGIT_W-1:0];
		unique case (rx.rx_byte) inside
			[CH_0:CH_9]:  entry.cls = aspf_pkg::CLS_DIGIT;
			CH_LF, CH_CR: entry.cls = aspf_pkg::CLS_CRLF;
			CH_A:         entry.cls = aspf_pkg::CLS_A;
			CH_B:         entry.cls = aspf_pkg::CLS_B;
			CH_D:         entry.cls = aspf_pkg::CLS_D;
			CH_E:         entry.cls = aspf_pkg::CLS_E;
			CH_I:         entry.cls = aspf_pkg::CLS_I;
			CH_N:         entry.cls = aspf_pkg::CLS_N;
			CH_O:         entry.cls = aspf_pkg::CLS_O;
			CH_P:         entry.cls = aspf_pkg::CLS_P;
			CH_R:         entry.cls = aspf_pkg::CLS_R;
			CH_S:         entry.cls = aspf_pkg::CLS_S;
			CH_V:         entry.cls = aspf_pkg::CLS_V;
			CH_W:         entry.cls = aspf_pkg::CLS_W;
			default:      entry.cls = aspf_pkg::CLS_OTHER;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/aspf_queue.sv
`default_nettype none
module aspf_queue #(
	parameter int DEPTH = aspf_pkg::QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  aspf_pkg::q_entry_t   entry_in,
	input  wire                  pop,
	output aspf_pkg::q_entry_t   entry_out,
	output aspf_pkg::q_stat_t    stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	aspf_pkg::q_entry_t  mem_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CW-1:0]       cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign entry_out  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/aspf_back.sv
`default_nettype none
module aspf_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  aspf_pkg::q_entry_t   entry,
	input  aspf_pkg::q_stat_t    qs,
	output logic                 pop,
	aspf_res_if.source           res
);

	localparam int FW = aspf_pkg::FIELD_W;
	localparam int DW = aspf_pkg::DIGIT_W;
	localparam int KW = aspf_pkg::KIND_W;

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_TYPE = 2'd2;

	localparam int         LEAD_N   = 3;
	localparam int         ADDR_N   = 12;
	localparam logic [3:0] RUN_MAX  = 4'd15;
	localparam logic [1:0] SMALL_MAX = 2'd3;

	// literal steps
	localparam logic [3:0] ST_SSID_DONE = 4'd4;
	localparam logic [3:0] ST_PW_P      = 4'd5;
	localparam logic [3:0] ST_PW_W      = 4'd6;
	localparam logic [3:0] ST_PWD_DONE  = 4'd7;
	localparam logic [3:0] ST_OWER_END  = 4'd4;
	localparam logic [3:0] ST_POWER_DIG = 4'd5;
	localparam logic [3:0] ST_V_SEEN    = 4'd6;
	localparam logic [3:0] ST_ERSION_END = 4'd11;
	localparam logic [3:0] ST_VER_DIG   = 4'd12;
	localparam logic [3:0] ST_LIT2      = 4'd2;

	function automatic logic [FW-1:0] mul10_add(input logic [FW-1:0] a, input logic [DW-1:0] d);
		logic [13:0] t;
		t = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {10'b0, d};
		return t[FW-1:0];
	endfunction

	function automatic logic [FW-1:0] group3(input logic [DW-1:0] a, input logic [DW-1:0] b,
		input logic [DW-1:0] c);
		return {a, 6'b0} + {1'b0, a, 5'b0} + {4'b0, a, 2'b0}
			+ {3'b0, b, 3'b0} + {5'b0, b, 1'b0} + {6'b0, c};
	endfunction

	function automatic aspf_pkg::byte_cls_t ssid_cls(input logic [3:0] s);
		unique case (s)
			4'd0, 4'd1: return aspf_pkg::CLS_S;
			4'd2:       return aspf_pkg::CLS_I;
			default:    return aspf_pkg::CLS_D;
		endcase
	endfunction

	// expected class for step 1..4 of "OWER"
	function automatic aspf_pkg::byte_cls_t ower_cls(input logic [3:0] s);
		unique case (s)
			4'd1:    return aspf_pkg::CLS_O;
			4'd2:    return aspf_pkg::CLS_W;
			4'd3:    return aspf_pkg::CLS_E;
			default: return aspf_pkg::CLS_R;
		endcase
	endfunction

	// expected class for step 6..11 of "ERSION"
	function automatic aspf_pkg::byte_cls_t ersion_cls(input logic [3:0] s);
		unique case (s)
			4'd6:    return aspf_pkg::CLS_E;
			4'd7:    return aspf_pkg::CLS_R;
			4'd8:    return aspf_pkg::CLS_S;
			4'd9:    return aspf_pkg::CLS_I;
			4'd10:   return aspf_pkg::CLS_O;
			default: return aspf_pkg::CLS_N;
		endcase
	endfunction

	logic [1:0]     phase_q, n_phase;
	logic [KW-1:0]  kind_q, n_kind;
	logic [3:0]     step_q, n_step;
	logic           valid_q, n_valid;
	logic [3:0]     cnt_q, n_cnt;
	logic [1:0]     sfd_q, n_sfd;
	logic [FW-1:0]  pwr_q, n_pwr;
	logic [FW-1:0]  ver_q, n_ver;

	logic [DW-1:0]  lead_q [LEAD_N];
	logic [DW-1:0]  sr_q [ADDR_N];

	logic           lead_we, sr_shift, sr_clear, emit;
	logic           is_dig, close_ok;
	logic [DW-1:0]  want;
	logic [KW-1:0]  res_kind;

	logic           out_valid_q;
	logic [KW-1:0]  kind_out_q;
	logic [FW-1:0]  bright_q, a1_q, a2_q, a3_q, a4_q, batt_q, fw_q;

	assign pop    = !qs.empty && (!out_valid_q || res.ready);
	assign is_dig = (entry.cls == aspf_pkg::CLS_DIGIT);

	always_comb begin
		n_phase  = phase_q;
		n_kind   = kind_q;
		n_step   = step_q;
		n_valid  = valid_q;
		n_cnt    = cnt_q;
		n_sfd    = sfd_q;
		n_pwr    = pwr_q;
		n_ver    = ver_q;
		lead_we  = 1'b0;
		sr_shift = 1'b0;
		sr_clear = 1'b0;
		emit     = 1'b0;
		want     = '0;
		if (pop) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (entry.cls == aspf_pkg::CLS_A) begin
						n_phase  = PH_BODY;
						n_kind   = aspf_pkg::KIND_PENDING;
						n_step   = '0;
						n_valid  = 1'b1;
						n_cnt    = '0;
						n_sfd    = '0;
						n_pwr    = '0;
						n_ver    = '0;
						sr_clear = 1'b1;
					end
				end
				PH_BODY: begin
					if (entry.cls == aspf_pkg::CLS_B) begin
						n_phase = PH_TYPE;
					end else if (valid_q) begin
						if (kind_q == aspf_pkg::KIND_PENDING) begin
							if (is_dig && entry.dval >= 4'd1 && entry.dval <= 4'd6) begin
								n_kind = entry.dval[KW-1:0];
							end else begin
								n_kind  = aspf_pkg::KIND_UNKNOWN;
								n_valid = 1'b0;
							end
						end else begin
							unique case (kind_q) inside
								aspf_pkg::KIND_SETUP, aspf_pkg::KIND_CONFIRM: begin
									want = (step_q == '0) ? '0 : {1'b0, kind_q};
									if (step_q < ST_LIT2 && is_dig && entry.dval == want) begin
										n_step = step_q + 1'b1;
									end else begin
										n_valid = 1'b0;
									end
								end
								aspf_pkg::KIND_CRED, aspf_pkg::KIND_CRED_ERR: begin
									if (entry.cls == aspf_pkg::CLS_CRLF) begin
										n_valid = 1'b0;
									end else if (step_q < ST_SSID_DONE) begin
										if (entry.cls == ssid_cls(step_q)) n_step = step_q + 1'b1;
										else n_valid = 1'b0;
									end else if (step_q < ST_PWD_DONE) begin
										// hunt for "PWD" with restart on mismatch
										if (entry.cls == aspf_pkg::CLS_P) n_step = ST_PW_P;
										else if (step_q == ST_PW_P && entry.cls == aspf_pkg::CLS_W)
											n_step = ST_PW_W;
										else if (step_q == ST_PW_W && entry.cls == aspf_pkg::CLS_D)
											n_step = ST_PWD_DONE;
										else n_step = ST_SSID_DONE;
									end
								end
								aspf_pkg::KIND_STATUS: begin
									if (step_q == '0) begin
										if (is_dig) begin
											if (cnt_q < RUN_MAX) begin
												if (cnt_q < 4'(LEAD_N)) lead_we = 1'b1;
												else sr_shift = 1'b1;
												n_cnt = cnt_q + 1'b1;
											end
										end else if (entry.cls == aspf_pkg::CLS_P && cnt_q >= 4'd2) begin
											n_step = 4'd1;
										end else begin
											n_valid = 1'b0;
										end
									end else if (step_q <= ST_OWER_END) begin
										if (entry.cls == ower_cls(step_q)) n_step = step_q + 1'b1;
										else n_valid = 1'b0;
									end else if (step_q == ST_POWER_DIG) begin
										if (is_dig && sfd_q < SMALL_MAX) begin
											n_pwr = mul10_add(pwr_q, entry.dval);
											n_sfd = sfd_q + 1'b1;
										end else if (entry.cls == aspf_pkg::CLS_V && sfd_q != '0) begin
											n_step = ST_V_SEEN;
											n_sfd  = '0;
										end else begin
											n_valid = 1'b0;
										end
									end else if (step_q <= ST_ERSION_END) begin
										if (entry.cls == ersion_cls(step_q)) n_step = step_q + 1'b1;
										else n_valid = 1'b0;
									end else begin
										if (is_dig && sfd_q < SMALL_MAX) begin
											n_ver = mul10_add(ver_q, entry.dval);
											n_sfd = sfd_q + 1'b1;
										end else begin
											n_valid = 1'b0;
										end
									end
								end
								aspf_pkg::KIND_LIGHT: begin
									if (is_dig && sfd_q < SMALL_MAX) begin
										n_pwr = mul10_add(pwr_q, entry.dval);
										n_sfd = sfd_q + 1'b1;
									end else begin
										n_valid = 1'b0;
									end
								end
								default: n_valid = 1'b0;
							endcase
						end
					end
				end
				PH_TYPE: begin
					emit    = 1'b1;
					n_phase = PH_HUNT;
				end
				default: n_phase = PH_HUNT;
			endcase
		end
	end

	// frame close: type byte repeats the body's first character; body complete (end step; light: a digit)
	always_comb begin
		close_ok = valid_q && kind_q != aspf_pkg::KIND_UNKNOWN
			&& kind_q != aspf_pkg::KIND_PENDING && is_dig && entry.dval == {1'b0, kind_q};
		unique case (kind_q) inside
			aspf_pkg::KIND_SETUP, aspf_pkg::KIND_CONFIRM:
				close_ok = close_ok && step_q == ST_LIT2;
			aspf_pkg::KIND_CRED, aspf_pkg::KIND_CRED_ERR:
				close_ok = close_ok && step_q == ST_PWD_DONE;
			aspf_pkg::KIND_STATUS:
				close_ok = close_ok && step_q == ST_VER_DIG && sfd_q != '0;
			default:
				close_ok = close_ok && sfd_q != '0;
		endcase
		res_kind = close_ok ? kind_q : aspf_pkg::KIND_UNKNOWN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			kind_q  <= aspf_pkg::KIND_UNKNOWN;
			step_q  <= '0;
			valid_q <= 1'b1;
			cnt_q   <= '0;
			sfd_q   <= '0;
			pwr_q   <= '0;
			ver_q   <= '0;
		end else begin
			phase_q <= n_phase;
			kind_q  <= n_kind;
			step_q  <= n_step;
			valid_q <= n_valid;
			cnt_q   <= n_cnt;
			sfd_q   <= n_sfd;
			pwr_q   <= n_pwr;
			ver_q   <= n_ver;
		end
	end

	// run digits: first three kept apart, the rest shift in from the low end
	always_ff @(posedge clk) begin
		if (lead_we) begin
			lead_q[cnt_q[1:0]] <= entry.dval;
		end
		if (sr_clear) begin
			for (int i = 0; i < ADDR_N; i++) sr_q[i] <= '0;
		end else if (sr_shift) begin
			sr_q[0] <= entry.dval;
			for (int i = 1; i < ADDR_N; i++) sr_q[i] <= sr_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_out_q <= res_kind;
			bright_q <= '0;
			a1_q     <= '0;
			a2_q     <= '0;
			a3_q     <= '0;
			a4_q     <= '0;
			batt_q   <= '0;
			fw_q     <= '0;
			if (res_kind == aspf_pkg::KIND_STATUS) begin
				batt_q <= pwr_q;
				fw_q   <= ver_q;
				a2_q   <= group3(sr_q[5], sr_q[4], sr_q[3]);
				a3_q   <= group3(sr_q[8], sr_q[7], sr_q[6]);
				a4_q   <= group3(sr_q[11], sr_q[10], sr_q[9]);
				if (cnt_q == 4'd2) begin
					bright_q <= {{(FW-DW){1'b0}}, lead_q[0]};
					a1_q     <= {{(FW-DW){1'b0}}, lead_q[1]};
				end else if (cnt_q == 4'd3) begin
					bright_q <= group3('0, lead_q[0], lead_q[1]);
					a1_q     <= {{(FW-DW){1'b0}}, lead_q[2]};
				end else begin
					bright_q <= group3(lead_q[0], lead_q[1], lead_q[2]);
					a1_q     <= group3(sr_q[2], sr_q[1], sr_q[0]);
				end
			end
		end
	end

	assign res.valid            = out_valid_q;
	assign res.frame_kind       = kind_out_q;
	assign res.brightness       = bright_q;
	assign res.addr_first       = a1_q;
	assign res.addr_second      = a2_q;
	assign res.addr_third       = a3_q;
	assign res.addr_fourth      = a4_q;
	assign res.battery_level    = batt_q;
	assign res.firmware_version = fw_q;

endmodule
`default_nettype wire
